// ===== rtl/hsv_pkg.sv =====
`timescale 1ns / 1ps
package hsv_pkg;
  localparam int HUE_BITS = 9;
  localparam int HUE_SECTOR = 60;
  localparam int HUE_GREEN = 120;
  localparam int HUE_BLUE = 240;
  localparam int HUE_FULL = 360;
endpackage

// ===== rtl/hsv_front.sv =====
`timescale 1ns / 1ps
module hsv_front #(
  parameter int W = 8,
  parameter int RW = 28,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  red,
  input  logic [W-1:0]  green,
  input  logic [W-1:0]  blue,
  output logic          out_valid,
  output logic [RW-1:0] rem_h,
  output logic [DW-1:0] den_h,
  output logic [RW-1:0] rem_s,
  output logic [DW-1:0] den_s,
  output logic [W-1:0]  val
);
  import hsv_pkg::*;

  localparam int NW = W + 11;
  localparam logic [W-1:0] MAXV = {W{1'b1}};

  logic [W-1:0]  mx;
  logic [W-1:0]  mn;
  logic [W-1:0]  d;
  logic [NW-1:0] dx;
  logic [NW-1:0] num;
  logic [NW-1:0] nh;
  logic [2*W+1:0] ns;

  function automatic logic [NW-1:0] sixty(input logic [W-1:0] x);
    return NW'(HUE_SECTOR) * NW'(x);
  endfunction

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    dx = NW'(d);
    if (red == mx) begin
      if (green >= blue) num = sixty(green - blue);
      else num = NW'(HUE_FULL) * dx - sixty(blue - green);
    end else if (green == mx) begin
      if (blue >= red) num = NW'(HUE_GREEN) * dx + sixty(blue - red);
      else num = NW'(HUE_GREEN) * dx - sixty(red - blue);
    end else begin
      if (red >= green) num = NW'(HUE_BLUE) * dx + sixty(red - green);
      else num = NW'(HUE_BLUE) * dx - sixty(green - red);
    end
    nh = (num << 1) + dx;
    ns = ((2*W+2)'(MAXV) * (2*W+2)'(d) << 1) + (2*W+2)'(mx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= mx;
      if (d == '0) begin
        rem_h <= '0;
        den_h <= DW'(1);
        rem_s <= '0;
        den_s <= DW'(1);
      end else begin
        rem_h <= RW'(nh);
        den_h <= DW'(dx) << 1;
        rem_s <= RW'(ns);
        den_s <= DW'(mx) << 1;
      end
    end
  end
endmodule

// ===== rtl/hsv_div_cell.sv =====
`timescale 1ns / 1ps
module hsv_div_cell #(
  parameter int W = 8,
  parameter int RW = 28,
  parameter int DW = 10,
  parameter int QB = 9,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] rem_h_in,
  input  logic [DW-1:0] den_h_in,
  input  logic [QB-1:0] q_h_in,
  input  logic [RW-1:0] rem_s_in,
  input  logic [DW-1:0] den_s_in,
  input  logic [QB-1:0] q_s_in,
  input  logic [W-1:0]  val_in,
  output logic          out_valid,
  output logic [RW-1:0] rem_h,
  output logic [DW-1:0] den_h,
  output logic [QB-1:0] q_h,
  output logic [RW-1:0] rem_s,
  output logic [DW-1:0] den_s,
  output logic [QB-1:0] q_s,
  output logic [W-1:0]  val
);
  logic [RW:0] trial_h;
  logic [RW:0] trial_s;

  always_comb begin
    trial_h = {1'b0, rem_h_in} - ((RW+1)'(den_h_in) << STEP);
    trial_s = {1'b0, rem_s_in} - ((RW+1)'(den_s_in) << STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_h <= den_h_in;
      den_s <= den_s_in;
      val <= val_in;
      if (!trial_h[RW]) begin
        rem_h <= trial_h[RW-1:0];
        q_h <= q_h_in | (QB'(1) << STEP);
      end else begin
        rem_h <= rem_h_in;
        q_h <= q_h_in;
      end
      if (!trial_s[RW]) begin
        rem_s <= trial_s[RW-1:0];
        q_s <= q_s_in | (QB'(1) << STEP);
      end else begin
        rem_s <= rem_s_in;
        q_s <= q_s_in;
      end
    end
  end
endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// RGB to HSV pixel converter.
// Slave stream carries one pixel per item: red, green and blue channels of
// CHANNEL_BITS each. Master stream returns hue in whole degrees (0..360),
// saturation (0..full scale) and value (largest channel), one item per pixel,
// in order.
// A first stage finds max, min and the hue sector and forms numerator and
// denominator of both ratios; a row of max(9, CHANNEL_BITS) division cells
// then produces one quotient bit per cell for hue and saturation together.
// Throughput is one pixel per cycle while the receiver does not stall.
// The last cell is the output register. When the receiver stalls, the whole
// row holds and s_axis_tready drops only while a finished item is waiting;
// s_axis_tready = !m_axis_tvalid || m_axis_tready.
// Reset clears all item valid flags; no item is in flight afterwards.
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS = 8,
  localparam int IN_W = ((3 * CHANNEL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((hsv_pkg::HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // red_in, green_in, blue_in
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // hue_deg, sat_out, val_out
);
  import hsv_pkg::*;

  localparam int W = CHANNEL_BITS;
  localparam int QB = (W > HUE_BITS) ? W : HUE_BITS;
  localparam int DW = W + 2;
  localparam int RW = 2 * W + QB + 2;

  logic          en;
  logic          vld [QB+1];
  logic [RW-1:0] rem_h [QB+1];
  logic [DW-1:0] den_h [QB+1];
  logic [QB-1:0] q_h [QB+1];
  logic [RW-1:0] rem_s [QB+1];
  logic [DW-1:0] den_s [QB+1];
  logic [QB-1:0] q_s [QB+1];
  logic [W-1:0]  val [QB+1];

  assign en = !vld[QB] || m_axis_tready;
  assign s_axis_tready = en;
  assign q_h[0] = '0;
  assign q_s[0] = '0;

  hsv_front #(.W(W), .RW(RW), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_axis_tvalid),
    .red(s_axis_tdata[W-1:0]),
    .green(s_axis_tdata[2*W-1:W]),
    .blue(s_axis_tdata[3*W-1:2*W]),
    .out_valid(vld[0]), .rem_h(rem_h[0]), .den_h(den_h[0]),
    .rem_s(rem_s[0]), .den_s(den_s[0]), .val(val[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_cell
    hsv_div_cell #(.W(W), .RW(RW), .DW(DW), .QB(QB), .STEP(QB - 1 - k)) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_valid(vld[k]),
      .rem_h_in(rem_h[k]), .den_h_in(den_h[k]), .q_h_in(q_h[k]),
      .rem_s_in(rem_s[k]), .den_s_in(den_s[k]), .q_s_in(q_s[k]),
      .val_in(val[k]),
      .out_valid(vld[k+1]), .rem_h(rem_h[k+1]), .den_h(den_h[k+1]), .q_h(q_h[k+1]),
      .rem_s(rem_s[k+1]), .den_s(den_s[k+1]), .q_s(q_s[k+1]), .val(val[k+1])
    );
  end

  assign m_axis_tvalid = vld[QB];
  assign m_axis_tdata = OUT_W'({val[QB], q_s[QB][W-1:0], q_h[QB][HUE_BITS-1:0]});
endmodule

// ===== rtl/hsv_checker.sv =====
`timescale 1ns / 1ps
module hsv_checker #(
  parameter int CHANNEL_BITS = 8,
  localparam int IN_W = ((3 * CHANNEL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((hsv_pkg::HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);
  import hsv_pkg::*;

  localparam int W = CHANNEL_BITS;

  logic [HUE_BITS-1:0] hue;
  logic [W-1:0]        sat;
  logic [W-1:0]        val;

  assign hue = m_axis_tdata[HUE_BITS-1:0];
  assign sat = m_axis_tdata[HUE_BITS+W-1:HUE_BITS];
  assign val = m_axis_tdata[HUE_BITS+2*W-1:HUE_BITS+W];

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output item after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

  a_hue: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> hue <= HUE_BITS'(HUE_FULL))
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && val == '0 |-> sat == '0 && hue == '0)
    else $error("black pixel with hue or saturation");
endmodule

bind rgb_to_hsv_converter hsv_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hsv_checker (.*);
